// ===== design/fps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flight phase sequencer package
// Shared widths, codes, register defaults and the types that move between
// the sequencer modules.
// ----------------------------------------------------------------------------
package fps_pkg;

   localparam int TIMER_WIDTH     = 24;
   localparam int SAMPLE_WIDTH    = 10;
   localparam int DEBOUNCE_WIDTH  = 16;
   localparam int SETPOINT_WIDTH  = 11;
   localparam int STATUS_WIDTH    = 6;
   localparam int PHASE_WIDTH     = 2;
   localparam int COMMAND_WIDTH   = 2;
   localparam int LEVEL_COUNT     = 3;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 24;

   // Item commands.
   localparam logic [COMMAND_WIDTH-1:0] CMD_TICK       = 2'd0;
   localparam logic [COMMAND_WIDTH-1:0] CMD_FORCE_LO   = 2'd1;
   localparam logic [COMMAND_WIDTH-1:0] CMD_FORCE_SODS = 2'd2;
   localparam logic [COMMAND_WIDTH-1:0] CMD_FORCE_SOE  = 2'd3;

   // Flight phases.
   localparam logic [PHASE_WIDTH-1:0] PHASE_BOOT       = 2'd0;
   localparam logic [PHASE_WIDTH-1:0] PHASE_LIFT_OFF   = 2'd1;
   localparam logic [PHASE_WIDTH-1:0] PHASE_DATA_STORE = 2'd2;
   localparam logic [PHASE_WIDTH-1:0] PHASE_EXPERIMENT = 2'd3;

   // Status bits.
   localparam logic [STATUS_WIDTH-1:0] ST_POWER  = 6'h01;
   localparam logic [STATUS_WIDTH-1:0] ST_LO     = 6'h02;
   localparam logic [STATUS_WIDTH-1:0] ST_LASER  = 6'h04;
   localparam logic [STATUS_WIDTH-1:0] ST_SODS   = 6'h08;
   localparam logic [STATUS_WIDTH-1:0] ST_SOE    = 6'h10;
   localparam logic [STATUS_WIDTH-1:0] ST_HEATER = 6'h20;

   // Debounced level positions.
   localparam int LVL_LO   = 0;
   localparam int LVL_SODS = 1;
   localparam int LVL_SOE  = 2;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_TICKS    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POWER_OFF_TICKS   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACQUISITION_TICKS = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SETPOINT_STEP     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DISAGREE_LIMIT    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RANGE_LOW         = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RANGE_HIGH        = 3'd6;

   // Register reset values.
   localparam logic [DEBOUNCE_WIDTH-1:0] DEF_DEBOUNCE_TICKS    = 16'd10;
   localparam logic [TIMER_WIDTH-1:0]    DEF_POWER_OFF_TICKS   = 24'd600000;
   localparam logic [TIMER_WIDTH-1:0]    DEF_ACQUISITION_TICKS = 24'd300000;
   localparam logic [SAMPLE_WIDTH-1:0]   DEF_SETPOINT_STEP     = 10'd64;
   localparam logic [SAMPLE_WIDTH-1:0]   DEF_DISAGREE_LIMIT    = 10'd32;
   localparam logic [SAMPLE_WIDTH-1:0]   DEF_RANGE_LOW         = 10'd100;
   localparam logic [SAMPLE_WIDTH-1:0]   DEF_RANGE_HIGH        = 10'd900;

   localparam logic [SETPOINT_WIDTH-1:0] SETPOINT_MAX = 11'h7FF;

   typedef struct packed {
      logic [DEBOUNCE_WIDTH-1:0] debounce_ticks;
      logic [TIMER_WIDTH-1:0]    power_off_ticks;
      logic [TIMER_WIDTH-1:0]    acquisition_ticks;
      logic [SAMPLE_WIDTH-1:0]   setpoint_step;
      logic [SAMPLE_WIDTH-1:0]   disagree_limit;
      logic [SAMPLE_WIDTH-1:0]   range_low;
      logic [SAMPLE_WIDTH-1:0]   range_high;
   } cfg_type;

   typedef struct packed {
      logic [COMMAND_WIDTH-1:0] command;
      logic                     lo_level;
      logic                     sods_level;
      logic                     soe_level;
      logic [SAMPLE_WIDTH-1:0]  temp_cell;
      logic [SAMPLE_WIDTH-1:0]  temp_heater;
      logic [SAMPLE_WIDTH-1:0]  temp_base;
   } req_type;

   typedef struct packed {
      logic [PHASE_WIDTH-1:0]    phase;
      logic [STATUS_WIDTH-1:0]   status_bits;
      logic                      laser_out;
      logic                      camera_acquire;
      logic                      acquisition_ended;
      logic                      control_on_heater_probe;
      logic [SETPOINT_WIDTH-1:0] heater_setpoint;
      logic [LEVEL_COUNT-1:0]    debounced_levels;
   } rsp_type;

endpackage
`default_nettype wire

// ===== design/fps_debounce.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Launch signal debouncer
// Holds the debounced level, pending flag and settle count of one raw signal
// and updates them on every tick.
// ----------------------------------------------------------------------------
module fps_debounce (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                tick,
   input  wire logic                                raw_level,
   input  wire logic [fps_pkg::DEBOUNCE_WIDTH-1:0]  limit,
   output logic                                     level_next
);

   logic                               level_ff, level_in;
   logic                               pending_ff, pending_in;
   logic [fps_pkg::DEBOUNCE_WIDTH-1:0] count_ff, count_in;

   always_comb begin
      level_in   = level_ff;
      pending_in = pending_ff;
      count_in   = count_ff;
      if (tick) begin
         if (raw_level != level_ff) begin
            // The first differing tick starts the count; later ones add to it.
            if (!pending_ff) begin
               pending_in = 1'b1;
               count_in   = '0;
            end else if (count_ff != '1) begin
               count_in = count_ff + 1'b1;
            end
            if (count_in >= limit) begin
               level_in   = ~level_ff;
               pending_in = 1'b0;
            end
         end else begin
            pending_in = 1'b0;
         end
      end
   end

   assign level_next = level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= 1'b0;
         pending_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         level_ff   <= level_in;
         pending_ff <= pending_in;
         count_ff   <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/fps_exp_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Experiment entry calculation
// Decides whether the heater-side probe takes over as control sensor and
// forms the saturated heater setpoint from the cell reading.
// ----------------------------------------------------------------------------
module fps_exp_calc (
   input  wire fps_pkg::cfg_type                    cfg,
   input  wire logic [fps_pkg::SAMPLE_WIDTH-1:0]    temp_cell,
   input  wire logic [fps_pkg::SAMPLE_WIDTH-1:0]    temp_heater,
   input  wire logic [fps_pkg::SAMPLE_WIDTH-1:0]    temp_base,
   output logic                                     choose_heater,
   output logic [fps_pkg::SETPOINT_WIDTH-1:0]       setpoint
);

   logic [fps_pkg::SAMPLE_WIDTH-1:0] diff_cell_heater;
   logic [fps_pkg::SAMPLE_WIDTH-1:0] diff_cell_base;
   logic [fps_pkg::SAMPLE_WIDTH-1:0] diff_heater_base;
   logic [fps_pkg::SAMPLE_WIDTH:0]   setpoint_sum;

   assign diff_cell_heater = (temp_cell > temp_heater) ? temp_cell - temp_heater
                                                       : temp_heater - temp_cell;
   assign diff_cell_base   = (temp_cell > temp_base) ? temp_cell - temp_base
                                                     : temp_base - temp_cell;
   assign diff_heater_base = (temp_heater > temp_base) ? temp_heater - temp_base
                                                       : temp_base - temp_heater;

   assign choose_heater = (diff_cell_heater > cfg.disagree_limit) &&
                          (diff_cell_base > diff_heater_base) &&
                          (temp_cell < cfg.range_high) &&
                          (temp_cell > cfg.range_low);

   assign setpoint_sum = {1'b0, temp_cell} + {1'b0, cfg.setpoint_step};

   always_comb begin
      if (setpoint_sum > fps_pkg::SETPOINT_MAX) begin
         setpoint = fps_pkg::SETPOINT_MAX;
      end else begin
         setpoint = fps_pkg::SETPOINT_WIDTH'(setpoint_sum);
      end
   end

endmodule
`default_nettype wire

// ===== design/fps_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Phase sequencer core
// Holds the phase, status, countdown and output state and applies one item
// per step: countdowns, debounce and chained phase entries on a tick, or a
// single forced phase entry. Presents the updated outputs of the step.
// ----------------------------------------------------------------------------
module fps_sequencer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire fps_pkg::req_type  req,
   input  wire fps_pkg::cfg_type  cfg,
   output fps_pkg::rsp_type       result
);

   logic [fps_pkg::PHASE_WIDTH-1:0]    phase_ff, phase_in;
   logic [fps_pkg::STATUS_WIDTH-1:0]   status_ff, status_in;
   logic [fps_pkg::TIMER_WIDTH-1:0]    power_count_ff, power_count_in;
   logic [fps_pkg::TIMER_WIDTH-1:0]    acquire_count_ff, acquire_count_in;
   logic                               power_armed_ff, power_armed_in;
   logic                               acquire_armed_ff, acquire_armed_in;
   logic                               laser_ff, laser_in;
   logic                               camera_ff, camera_in;
   logic                               select_ff, select_in;
   logic [fps_pkg::SETPOINT_WIDTH-1:0] setpoint_ff, setpoint_in;

   logic                               tick;
   logic                               ended;
   logic [fps_pkg::LEVEL_COUNT-1:0]    levels;
   logic                               choose_heater;
   logic [fps_pkg::SETPOINT_WIDTH-1:0] setpoint_calc;
   logic                               enter_lo, enter_sods, enter_soe;

   assign tick = step && (req.command == fps_pkg::CMD_TICK);

   fps_debounce u_debounce_lo (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .raw_level  (req.lo_level),
      .limit      (cfg.debounce_ticks),
      .level_next (levels[fps_pkg::LVL_LO])
   );

   fps_debounce u_debounce_sods (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .raw_level  (req.sods_level),
      .limit      (cfg.debounce_ticks),
      .level_next (levels[fps_pkg::LVL_SODS])
   );

   fps_debounce u_debounce_soe (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .raw_level  (req.soe_level),
      .limit      (cfg.debounce_ticks),
      .level_next (levels[fps_pkg::LVL_SOE])
   );

   fps_exp_calc u_exp_calc (
      .cfg           (cfg),
      .temp_cell     (req.temp_cell),
      .temp_heater   (req.temp_heater),
      .temp_base     (req.temp_base),
      .choose_heater (choose_heater),
      .setpoint      (setpoint_calc)
   );

   // A tick may chain lift-off, data storage and experiment entries in order.
   always_comb begin
      enter_lo   = 1'b0;
      enter_sods = 1'b0;
      enter_soe  = 1'b0;
      if (step) begin
         case (req.command)
            fps_pkg::CMD_FORCE_LO:   enter_lo = 1'b1;
            fps_pkg::CMD_FORCE_SODS: enter_sods = 1'b1;
            fps_pkg::CMD_FORCE_SOE:  enter_soe = 1'b1;
            default: begin
               enter_lo   = levels[fps_pkg::LVL_LO] && (phase_ff == fps_pkg::PHASE_BOOT);
               enter_sods = levels[fps_pkg::LVL_SODS] &&
                            ((phase_ff == fps_pkg::PHASE_LIFT_OFF) || enter_lo);
               enter_soe  = levels[fps_pkg::LVL_SOE] &&
                            ((phase_ff == fps_pkg::PHASE_DATA_STORE) || enter_sods);
            end
         endcase
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      status_in        = status_ff;
      power_count_in   = power_count_ff;
      acquire_count_in = acquire_count_ff;
      power_armed_in   = power_armed_ff;
      acquire_armed_in = acquire_armed_ff;
      laser_in         = laser_ff;
      camera_in        = camera_ff;
      select_in        = select_ff;
      setpoint_in      = setpoint_ff;
      ended            = 1'b0;

      if (tick) begin
         // A countdown fires at one or zero, so a zero load behaves like one.
         if (acquire_armed_ff) begin
            if (acquire_count_ff <= fps_pkg::TIMER_WIDTH'(1)) begin
               acquire_count_in = '0;
               acquire_armed_in = 1'b0;
               camera_in        = 1'b0;
               ended            = 1'b1;
            end else begin
               acquire_count_in = acquire_count_ff - 1'b1;
            end
         end
         if (power_armed_ff) begin
            if (power_count_ff <= fps_pkg::TIMER_WIDTH'(1)) begin
               power_count_in = '0;
               power_armed_in = 1'b0;
               laser_in       = 1'b0;
               status_in      = status_in & ~(fps_pkg::ST_HEATER | fps_pkg::ST_LASER);
            end else begin
               power_count_in = power_count_ff - 1'b1;
            end
         end
      end

      if (enter_lo) begin
         power_count_in = cfg.power_off_ticks;
         power_armed_in = 1'b1;
         phase_in       = fps_pkg::PHASE_LIFT_OFF;
         laser_in       = 1'b1;
         status_in      = status_in | fps_pkg::ST_LO | fps_pkg::ST_LASER;
      end
      if (enter_sods) begin
         camera_in        = 1'b1;
         acquire_count_in = cfg.acquisition_ticks;
         acquire_armed_in = 1'b1;
         phase_in         = fps_pkg::PHASE_DATA_STORE;
         status_in        = status_in | fps_pkg::ST_SODS;
      end
      if (enter_soe) begin
         select_in   = select_ff | choose_heater;
         setpoint_in = setpoint_calc;
         phase_in    = fps_pkg::PHASE_EXPERIMENT;
         status_in   = status_in | fps_pkg::ST_SOE | fps_pkg::ST_HEATER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= fps_pkg::PHASE_BOOT;
         status_ff        <= fps_pkg::ST_POWER;
         power_count_ff   <= '0;
         acquire_count_ff <= '0;
         power_armed_ff   <= 1'b0;
         acquire_armed_ff <= 1'b0;
         laser_ff         <= 1'b0;
         camera_ff        <= 1'b0;
         select_ff        <= 1'b0;
         setpoint_ff      <= '0;
      end else begin
         phase_ff         <= phase_in;
         status_ff        <= status_in;
         power_count_ff   <= power_count_in;
         acquire_count_ff <= acquire_count_in;
         power_armed_ff   <= power_armed_in;
         acquire_armed_ff <= acquire_armed_in;
         laser_ff         <= laser_in;
         camera_ff        <= camera_in;
         select_ff        <= select_in;
         setpoint_ff      <= setpoint_in;
      end
   end

   assign result.phase                   = phase_in;
   assign result.status_bits             = status_in;
   assign result.laser_out               = laser_in;
   assign result.camera_acquire          = camera_in;
   assign result.acquisition_ended       = ended;
   assign result.control_on_heater_probe = select_in;
   assign result.heater_setpoint         = setpoint_in;
   assign result.debounced_levels        = levels;

endmodule
`default_nettype wire

// ===== design/flight_phase_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flight phase sequencer
// Steps the flight phases from millisecond ticks and forced commands,
// debounces the launch signals, runs the power-off and acquisition
// countdowns and sets up the heater control sensor and setpoint.
//
//   Channel   Ports                       Direction   Moves
//   req       req_valid / req_stall       in          one tick or command
//   rsp       rsp_valid / rsp_stall       out         one result per item
//   csr       csr_write_enable / index    in          register write
//
// An item passes from the input register to the result register when it
// steps, so a beat can be taken every cycle while rsp does not stall.
// The result register and the input register together give two beats of
// buffering, so a stall on rsp only backs up req once both are full.
// Reset is synchronous; it restores state and registers, not item data.
// ----------------------------------------------------------------------------
module flight_phase_sequencer (
   input  wire logic                                  clock,
   input  wire logic                                  reset,

   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [fps_pkg::COMMAND_WIDTH-1:0]     req_command,
   input  wire logic                                  req_lo_level,
   input  wire logic                                  req_sods_level,
   input  wire logic                                  req_soe_level,
   input  wire logic [fps_pkg::SAMPLE_WIDTH-1:0]      req_temp_cell,
   input  wire logic [fps_pkg::SAMPLE_WIDTH-1:0]      req_temp_heater,
   input  wire logic [fps_pkg::SAMPLE_WIDTH-1:0]      req_temp_base,

   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [fps_pkg::PHASE_WIDTH-1:0]            rsp_phase,
   output logic [fps_pkg::STATUS_WIDTH-1:0]           rsp_status_bits,
   output logic                                       rsp_laser_out,
   output logic                                       rsp_camera_acquire,
   output logic                                       rsp_acquisition_ended,
   output logic                                       rsp_control_on_heater_probe,
   output logic [fps_pkg::SETPOINT_WIDTH-1:0]         rsp_heater_setpoint,
   output logic [fps_pkg::LEVEL_COUNT-1:0]            rsp_debounced_levels,

   input  wire logic                                  csr_write_enable,
   input  wire logic [fps_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [fps_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   fps_pkg::cfg_type cfg_ff, cfg_in;
   fps_pkg::req_type req_ff, req_in;
   fps_pkg::rsp_type rsp_ff, rsp_in;
   logic             req_valid_ff, req_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             advance;
   logic             step;
   logic             req_take;

   // The held item moves on whenever the result register is free or drains.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            fps_pkg::CSR_DEBOUNCE_TICKS:
               cfg_in.debounce_ticks = csr_data[fps_pkg::DEBOUNCE_WIDTH-1:0];
            fps_pkg::CSR_POWER_OFF_TICKS:
               cfg_in.power_off_ticks = csr_data[fps_pkg::TIMER_WIDTH-1:0];
            fps_pkg::CSR_ACQUISITION_TICKS:
               cfg_in.acquisition_ticks = csr_data[fps_pkg::TIMER_WIDTH-1:0];
            fps_pkg::CSR_SETPOINT_STEP:
               cfg_in.setpoint_step = csr_data[fps_pkg::SAMPLE_WIDTH-1:0];
            fps_pkg::CSR_DISAGREE_LIMIT:
               cfg_in.disagree_limit = csr_data[fps_pkg::SAMPLE_WIDTH-1:0];
            fps_pkg::CSR_RANGE_LOW:
               cfg_in.range_low = csr_data[fps_pkg::SAMPLE_WIDTH-1:0];
            fps_pkg::CSR_RANGE_HIGH:
               cfg_in.range_high = csr_data[fps_pkg::SAMPLE_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks    <= fps_pkg::DEF_DEBOUNCE_TICKS;
         cfg_ff.power_off_ticks   <= fps_pkg::DEF_POWER_OFF_TICKS;
         cfg_ff.acquisition_ticks <= fps_pkg::DEF_ACQUISITION_TICKS;
         cfg_ff.setpoint_step     <= fps_pkg::DEF_SETPOINT_STEP;
         cfg_ff.disagree_limit    <= fps_pkg::DEF_DISAGREE_LIMIT;
         cfg_ff.range_low         <= fps_pkg::DEF_RANGE_LOW;
         cfg_ff.range_high        <= fps_pkg::DEF_RANGE_HIGH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      req_in             = req_ff;
      req_valid_in       = req_valid_ff && !step;
      if (req_take) begin
         req_in.command     = req_command;
         req_in.lo_level    = req_lo_level;
         req_in.sods_level  = req_sods_level;
         req_in.soe_level   = req_soe_level;
         req_in.temp_cell   = req_temp_cell;
         req_in.temp_heater = req_temp_heater;
         req_in.temp_base   = req_temp_base;
         req_valid_in       = 1'b1;
      end
   end

   fps_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .req    (req_ff),
      .cfg    (cfg_ff),
      .result (rsp_in)
   );

   always_comb begin
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid                   = rsp_valid_ff;
   assign rsp_phase                   = rsp_ff.phase;
   assign rsp_status_bits             = rsp_ff.status_bits;
   assign rsp_laser_out               = rsp_ff.laser_out;
   assign rsp_camera_acquire          = rsp_ff.camera_acquire;
   assign rsp_acquisition_ended       = rsp_ff.acquisition_ended;
   assign rsp_control_on_heater_probe = rsp_ff.control_on_heater_probe;
   assign rsp_heater_setpoint         = rsp_ff.heater_setpoint;
   assign rsp_debounced_levels        = rsp_ff.debounced_levels;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight phase sequencer testbench
// Sends ticks and forced phase commands through the valid/stall request
// channel while the result channel stalls on its own pattern. Each accepted
// request is run through a cycle-free model of the phase logic, and every
// result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   import fps_pkg::*;

   localparam int IDLE_LIMIT          = 5000;
   localparam int LONG_HOLD_CYCLES    = 60;
   localparam int DRAIN_SETTLE_CYCLES = 4;
   localparam int SEGMENT_ITEMS       = 35;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
   } stall_mode_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [COMMAND_WIDTH-1:0]   req_command;
   logic                       req_lo_level;
   logic                       req_sods_level;
   logic                       req_soe_level;
   logic [SAMPLE_WIDTH-1:0]    req_temp_cell;
   logic [SAMPLE_WIDTH-1:0]    req_temp_heater;
   logic [SAMPLE_WIDTH-1:0]    req_temp_base;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [PHASE_WIDTH-1:0]     rsp_phase;
   logic [STATUS_WIDTH-1:0]    rsp_status_bits;
   logic                       rsp_laser_out;
   logic                       rsp_camera_acquire;
   logic                       rsp_acquisition_ended;
   logic                       rsp_control_on_heater_probe;
   logic [SETPOINT_WIDTH-1:0]  rsp_heater_setpoint;
   logic [LEVEL_COUNT-1:0]     rsp_debounced_levels;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   flight_phase_sequencer dut (
      .clock                       (clock),
      .reset                       (reset),
      .req_valid                   (req_valid),
      .req_stall                   (req_stall),
      .req_command                 (req_command),
      .req_lo_level                (req_lo_level),
      .req_sods_level              (req_sods_level),
      .req_soe_level               (req_soe_level),
      .req_temp_cell               (req_temp_cell),
      .req_temp_heater             (req_temp_heater),
      .req_temp_base               (req_temp_base),
      .rsp_valid                   (rsp_valid),
      .rsp_stall                   (rsp_stall),
      .rsp_phase                   (rsp_phase),
      .rsp_status_bits             (rsp_status_bits),
      .rsp_laser_out               (rsp_laser_out),
      .rsp_camera_acquire          (rsp_camera_acquire),
      .rsp_acquisition_ended       (rsp_acquisition_ended),
      .rsp_control_on_heater_probe (rsp_control_on_heater_probe),
      .rsp_heater_setpoint         (rsp_heater_setpoint),
      .rsp_debounced_levels        (rsp_debounced_levels),
      .csr_write_enable            (csr_write_enable),
      .csr_index                   (csr_index),
      .csr_data                    (csr_data)
   );

   // Model of the sequencer: register settings and flight state.
   cfg_type                   model_cfg;
   logic [PHASE_WIDTH-1:0]    model_phase;
   logic [STATUS_WIDTH-1:0]   model_status;
   logic [LEVEL_COUNT-1:0]    model_levels;
   logic [LEVEL_COUNT-1:0]    model_pending;
   logic [DEBOUNCE_WIDTH-1:0] model_settle [LEVEL_COUNT];
   logic [TIMER_WIDTH-1:0]    power_left;
   logic [TIMER_WIDTH-1:0]    acquire_left;
   logic                      power_armed;
   logic                      acquire_armed;
   logic                      model_laser;
   logic                      model_camera;
   logic                      model_heater_probe;
   logic [SETPOINT_WIDTH-1:0] model_setpoint;

   rsp_type expected_reports [$];

   int  mismatch_count;
   int  results_checked;
   int  ticks_taken;
   int  forces_taken;
   int  end_pulses;
   int  experiment_entries;
   int  settings_applied;
   int  idle_cycles;
   int  burst_left;
   bit  sender_gaps_on;
   bit  long_hold_request;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [SAMPLE_WIDTH-1:0] sample_distance(
      input logic [SAMPLE_WIDTH-1:0] a, input logic [SAMPLE_WIDTH-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function void enter_lift_off();
      power_left = model_cfg.power_off_ticks;
      power_armed = 1'b1;
      model_phase = PHASE_LIFT_OFF;
      model_laser = 1'b1;
      model_status = model_status | ST_LO | ST_LASER;
   endfunction

   function void enter_data_storage();
      model_camera = 1'b1;
      acquire_left = model_cfg.acquisition_ticks;
      acquire_armed = 1'b1;
      model_phase = PHASE_DATA_STORE;
      model_status = model_status | ST_SODS;
   endfunction

   function void enter_experiment(input logic [SAMPLE_WIDTH-1:0] cell_reading,
                                  input logic [SAMPLE_WIDTH-1:0] heater,
                                  input logic [SAMPLE_WIDTH-1:0] base);
      logic [SETPOINT_WIDTH:0] sum;
      // The choice only ever moves to the heater probe; nothing moves it back.
      if (sample_distance(cell_reading, heater) > model_cfg.disagree_limit &&
          sample_distance(cell_reading, base) > sample_distance(heater, base) &&
          cell_reading < model_cfg.range_high && cell_reading > model_cfg.range_low) begin
         model_heater_probe = 1'b1;
      end
      sum = cell_reading + model_cfg.setpoint_step;
      model_setpoint = (sum > SETPOINT_MAX) ? SETPOINT_MAX : sum[SETPOINT_WIDTH-1:0];
      model_phase = PHASE_EXPERIMENT;
      model_status = model_status | ST_SOE | ST_HEATER;
      experiment_entries++;
   endfunction

   function rsp_type advance_flight_state(input req_type item);
      rsp_type                report;
      logic [LEVEL_COUNT-1:0] raw;
      logic                   ended;
      int                     i;
      ended = 1'b0;
      raw = {item.soe_level, item.sods_level, item.lo_level};
      case (item.command)
         CMD_TICK: begin
            if (acquire_armed) begin
               if (acquire_left <= 1) begin
                  acquire_left = '0;
                  acquire_armed = 1'b0;
                  model_camera = 1'b0;
                  ended = 1'b1;
               end else begin
                  acquire_left = acquire_left - 1'b1;
               end
            end
            if (power_armed) begin
               if (power_left <= 1) begin
                  power_left = '0;
                  power_armed = 1'b0;
                  model_laser = 1'b0;
                  model_status = model_status & ~(ST_HEATER | ST_LASER);
               end else begin
                  power_left = power_left - 1'b1;
               end
            end
            for (i = 0; i < LEVEL_COUNT; i++) begin
               if (raw[i] != model_levels[i]) begin
                  if (!model_pending[i]) begin
                     model_pending[i] = 1'b1;
                     model_settle[i] = '0;
                  end else if (model_settle[i] != '1) begin
                     model_settle[i] = model_settle[i] + 1'b1;
                  end
                  if (model_settle[i] >= model_cfg.debounce_ticks) begin
                     model_levels[i] = ~model_levels[i];
                     model_pending[i] = 1'b0;
                  end
               end else begin
                  model_pending[i] = 1'b0;
               end
            end
            // Checked in flight order so one tick can pass several phases.
            if (model_levels[LVL_LO] && model_phase == PHASE_BOOT) enter_lift_off();
            if (model_levels[LVL_SODS] && model_phase == PHASE_LIFT_OFF) enter_data_storage();
            if (model_levels[LVL_SOE] && model_phase == PHASE_DATA_STORE) begin
               enter_experiment(item.temp_cell, item.temp_heater, item.temp_base);
            end
         end
         CMD_FORCE_LO:   enter_lift_off();
         CMD_FORCE_SODS: enter_data_storage();
         CMD_FORCE_SOE:  enter_experiment(item.temp_cell, item.temp_heater, item.temp_base);
      endcase
      report.phase = model_phase;
      report.status_bits = model_status;
      report.laser_out = model_laser;
      report.camera_acquire = model_camera;
      report.acquisition_ended = ended;
      report.control_on_heater_probe = model_heater_probe;
      report.heater_setpoint = model_setpoint;
      report.debounced_levels = model_levels;
      return report;
   endfunction

   function automatic void compare_field(input string field, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   // Predict on every accepted request beat, check every accepted result beat.
   always @(posedge clock) begin : scoreboard
      req_type taken;
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            taken.command = req_command;
            taken.lo_level = req_lo_level;
            taken.sods_level = req_sods_level;
            taken.soe_level = req_soe_level;
            taken.temp_cell = req_temp_cell;
            taken.temp_heater = req_temp_heater;
            taken.temp_base = req_temp_base;
            want = advance_flight_state(taken);
            expected_reports.push_back(want);
            if (taken.command == CMD_TICK) ticks_taken++;
            else forces_taken++;
            if (want.acquisition_ended) end_pulses++;
         end
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (expected_reports.size() == 0) begin
               $error("result beat arrived with no prediction waiting");
               mismatch_count++;
            end else begin
               want = expected_reports.pop_front();
               compare_field("phase", want.phase, rsp_phase);
               compare_field("status_bits", want.status_bits, rsp_status_bits);
               compare_field("laser_out", want.laser_out, rsp_laser_out);
               compare_field("camera_acquire", want.camera_acquire, rsp_camera_acquire);
               compare_field("acquisition_ended", want.acquisition_ended,
                             rsp_acquisition_ended);
               compare_field("control_on_heater_probe", want.control_on_heater_probe,
                             rsp_control_on_heater_probe);
               compare_field("heater_setpoint", want.heater_setpoint, rsp_heater_setpoint);
               compare_field("debounced_levels", want.debounced_levels,
                             rsp_debounced_levels);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   // Result-side stall pattern; a requested long hold overrides it.
   initial begin
      stall_mode_type stall_mode;
      int             mode_left;
      int             hold_left;
      int             stall_tick;
      rsp_stall = 1'b0;
      mode_left = 0;
      hold_left = 0;
      stall_tick = 0;
      stall_mode = STALL_NONE;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            hold_left = LONG_HOLD_CYCLES;
            long_hold_request = 1'b0;
         end
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(40, 250);
         end
         mode_left--;
         stall_tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall = 1'b1;
         end else begin
            case (stall_mode)
               STALL_NONE:     rsp_stall = 1'b0;
               STALL_LIGHT:    rsp_stall = ($urandom_range(0, 3) == 0);
               STALL_HEAVY:    rsp_stall = ($urandom_range(0, 9) < 7);
               STALL_PERIODIC: rsp_stall = ((stall_tick % 5) < 2);
            endcase
         end
      end
   end

   // Ends the run when neither channel has moved a beat for too long.
   initial begin
      while (idle_cycles < IDLE_LIMIT) @(negedge clock);
      $display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("FAIL flight_phase_sequencer");
      $finish;
   end

   function automatic req_type make_item(input logic [COMMAND_WIDTH-1:0] cmd,
                                         input logic [LEVEL_COUNT-1:0]   raw,
                                         input logic [SAMPLE_WIDTH-1:0]  cell_reading,
                                         input logic [SAMPLE_WIDTH-1:0]  heater,
                                         input logic [SAMPLE_WIDTH-1:0]  base);
      req_type item;
      item.command = cmd;
      item.lo_level = raw[LVL_LO];
      item.sods_level = raw[LVL_SODS];
      item.soe_level = raw[LVL_SOE];
      item.temp_cell = cell_reading;
      item.temp_heater = heater;
      item.temp_base = base;
      return item;
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom_range(0, (1 << SAMPLE_WIDTH) - 1);
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat.
   task automatic send_item(input req_type item);
      if (sender_gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         burst_left--;
      end
      req_command = item.command;
      req_lo_level = item.lo_level;
      req_sods_level = item.sods_level;
      req_soe_level = item.soe_level;
      req_temp_cell = item.temp_cell;
      req_temp_heater = item.temp_heater;
      req_temp_base = item.temp_base;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_until_drained();
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (DRAIN_SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_register(input logic [CSR_INDEX_WIDTH-1:0] reg_index,
                                   input logic [CSR_DATA_WIDTH-1:0]  value);
      csr_write_enable = 1'b1;
      csr_index = reg_index;
      csr_data = value;
      case (reg_index)
         CSR_DEBOUNCE_TICKS:    model_cfg.debounce_ticks = value[DEBOUNCE_WIDTH-1:0];
         CSR_POWER_OFF_TICKS:   model_cfg.power_off_ticks = value[TIMER_WIDTH-1:0];
         CSR_ACQUISITION_TICKS: model_cfg.acquisition_ticks = value[TIMER_WIDTH-1:0];
         CSR_SETPOINT_STEP:     model_cfg.setpoint_step = value[SAMPLE_WIDTH-1:0];
         CSR_DISAGREE_LIMIT:    model_cfg.disagree_limit = value[SAMPLE_WIDTH-1:0];
         CSR_RANGE_LOW:         model_cfg.range_low = value[SAMPLE_WIDTH-1:0];
         CSR_RANGE_HIGH:        model_cfg.range_high = value[SAMPLE_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic apply_settings(input cfg_type settings);
      program_register(CSR_DEBOUNCE_TICKS, settings.debounce_ticks);
      program_register(CSR_POWER_OFF_TICKS, settings.power_off_ticks);
      program_register(CSR_ACQUISITION_TICKS, settings.acquisition_ticks);
      program_register(CSR_SETPOINT_STEP, settings.setpoint_step);
      program_register(CSR_DISAGREE_LIMIT, settings.disagree_limit);
      program_register(CSR_RANGE_LOW, settings.range_low);
      program_register(CSR_RANGE_HIGH, settings.range_high);
      settings_applied++;
   endtask

   task automatic test_power_on_defaults();
      send_item(make_item(CMD_TICK, 3'b000, '0, '0, '0));
      send_item(make_item(CMD_TICK, 3'b000, '1, '1, '1));
   endtask

   // Short debounce and countdowns: a cancelled glitch, a launch that runs
   // from boot to experiment in one tick, both countdowns firing, and forced
   // entries that ignore the raw levels.
   task automatic test_launch_chain();
      wait_until_drained();
      program_register(CSR_DEBOUNCE_TICKS, 1);
      program_register(CSR_POWER_OFF_TICKS, 3);
      program_register(CSR_ACQUISITION_TICKS, 1);
      send_item(make_item(CMD_TICK, 3'b001, 10'd300, 10'd310, 10'd0));
      send_item(make_item(CMD_TICK, 3'b000, 10'd300, 10'd310, 10'd0));
      send_item(make_item(CMD_TICK, 3'b111, 10'd300, 10'd310, 10'd0));
      send_item(make_item(CMD_TICK, 3'b111, 10'd300, 10'd310, 10'd0));
      send_item(make_item(CMD_TICK, 3'b111, 10'd300, 10'd310, 10'd0));
      send_item(make_item(CMD_TICK, 3'b111, 10'd300, 10'd310, 10'd0));
      send_item(make_item(CMD_TICK, 3'b111, 10'd300, 10'd310, 10'd0));
      send_item(make_item(CMD_TICK, 3'b101, 10'd300, 10'd310, 10'd0));
      send_item(make_item(CMD_TICK, 3'b111, 10'd300, 10'd310, 10'd0));
      send_item(make_item(CMD_TICK, 3'b000, 10'd300, 10'd310, 10'd0));
      send_item(make_item(CMD_TICK, 3'b000, 10'd300, 10'd310, 10'd0));
      send_item(make_item(CMD_FORCE_SODS, 3'b111, 10'd0, 10'd0, 10'd0));
      send_item(make_item(CMD_FORCE_LO, 3'b111, 10'd0, 10'd0, 10'd0));
      send_item(make_item(CMD_TICK, 3'b010, 10'd0, 10'd0, 10'd0));
      send_item(make_item(CMD_TICK, 3'b010, 10'd0, 10'd0, 10'd0));
   endtask

   // Every condition of the sensor choice fails once, the limit and range bounds
   // on their boundary, before the last entry hands control to the heater probe.
   task automatic test_sensor_choice();
      send_item(make_item(CMD_FORCE_SOE, 3'b000, 10'd500, 10'd532, 10'd600));
      send_item(make_item(CMD_FORCE_SOE, 3'b000, 10'd500, 10'd533, 10'd400));
      send_item(make_item(CMD_FORCE_SOE, 3'b000, 10'd100, 10'd600, 10'd600));
      send_item(make_item(CMD_FORCE_SOE, 3'b000, 10'd900, 10'd200, 10'd200));
      send_item(make_item(CMD_FORCE_SOE, 3'b000, '1, '0, '1));
      send_item(make_item(CMD_FORCE_SOE, 3'b000, '0, '1, '0));
      send_item(make_item(CMD_FORCE_SODS, 3'b000, '0, '0, '0));
      send_item(make_item(CMD_FORCE_SOE, 3'b000, 10'd101, 10'd899, 10'd899));
   endtask

   // The result side holds off while requests keep coming, so the block
   // fills and stalls its input; then the sender waits for every result.
   task automatic test_backpressure();
      int n;
      sender_gaps_on = 1'b0;
      @(posedge clock);
      long_hold_request = 1'b1;
      @(negedge clock);
      for (n = 0; n < 16; n++) begin
         send_item(make_item((n % 4 == 3) ? CMD_FORCE_LO : CMD_TICK,
                             $urandom_range(0, 7), pick_sample(), pick_sample(),
                             pick_sample()));
      end
      wait_until_drained();
   endtask

   // A well-formed segment restarts at lift-off and raises the storage and
   // experiment signals in flight order, with glitches and a few forced
   // commands; a broken one drives random levels and commands.
   task automatic run_flight_segment(input int item_total, input bit well_formed);
      logic [LEVEL_COUNT-1:0]   raw;
      logic [COMMAND_WIDTH-1:0] cmd;
      int                       sods_rise;
      int                       soe_rise;
      int                       glitch_bit;
      int                       n;
      sods_rise = $urandom_range(2, item_total / 2);
      soe_rise = $urandom_range(sods_rise + 1, item_total - 1);
      for (n = 0; n < item_total; n++) begin
         if (well_formed) begin
            raw[LVL_LO] = 1'b1;
            raw[LVL_SODS] = (n >= sods_rise);
            raw[LVL_SOE] = (n >= soe_rise);
            if ($urandom_range(0, 9) == 0) begin
               glitch_bit = $urandom_range(0, LEVEL_COUNT - 1);
               raw[glitch_bit] = ~raw[glitch_bit];
            end
            if (n == 0) cmd = CMD_FORCE_LO;
            else if ($urandom_range(0, 19) == 0) cmd = $urandom_range(CMD_FORCE_LO, CMD_FORCE_SOE);
            else cmd = CMD_TICK;
         end else begin
            raw = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) cmd = $urandom_range(CMD_FORCE_LO, CMD_FORCE_SOE);
            else cmd = CMD_TICK;
         end
         send_item(make_item(cmd, raw, pick_sample(), pick_sample(), pick_sample()));
      end
   endtask

   task automatic test_random_flights();
      cfg_type settings;
      int      p;
      int      s;
      for (p = 0; p < 8; p++) begin
         if (p == 0) begin
            settings.debounce_ticks = '0;
            settings.power_off_ticks = 1;
            settings.acquisition_ticks = 1;
            settings.setpoint_step = '0;
            settings.disagree_limit = '0;
            settings.range_low = '0;
            settings.range_high = '1;
         end else if (p == 1) begin
            settings.debounce_ticks = '1;
            settings.power_off_ticks = '1;
            settings.acquisition_ticks = '1;
            settings.setpoint_step = '1;
            settings.disagree_limit = '1;
            settings.range_low = '1;
            settings.range_high = '0;
         end else begin
            settings.debounce_ticks = (p % 3 == 2) ? $urandom_range(0, 40) : $urandom_range(0, 4);
            settings.power_off_ticks = (p == 6) ? $urandom_range(1, (1 << TIMER_WIDTH) - 1)
                                                : $urandom_range(1, 60);
            settings.acquisition_ticks = (p == 6) ? $urandom_range(1, (1 << TIMER_WIDTH) - 1)
                                                  : $urandom_range(1, 60);
            settings.setpoint_step = $urandom_range(0, 1023);
            settings.disagree_limit = $urandom_range(0, 300);
            settings.range_low = $urandom_range(0, 400);
            settings.range_high = $urandom_range(500, 1023);
         end
         wait_until_drained();
         apply_settings(settings);
         for (s = 0; s < 3; s++) begin
            sender_gaps_on = ($urandom_range(0, 3) != 0);
            run_flight_segment(SEGMENT_ITEMS, $urandom_range(0, 3) != 0);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_TICK;
      req_lo_level = 1'b0;
      req_sods_level = 1'b0;
      req_soe_level = 1'b0;
      req_temp_cell = '0;
      req_temp_heater = '0;
      req_temp_base = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_DEBOUNCE_TICKS;
      csr_data = '0;
      sender_gaps_on = 1'b0;
      long_hold_request = 1'b0;
      burst_left = 0;
      model_cfg.debounce_ticks = DEF_DEBOUNCE_TICKS;
      model_cfg.power_off_ticks = DEF_POWER_OFF_TICKS;
      model_cfg.acquisition_ticks = DEF_ACQUISITION_TICKS;
      model_cfg.setpoint_step = DEF_SETPOINT_STEP;
      model_cfg.disagree_limit = DEF_DISAGREE_LIMIT;
      model_cfg.range_low = DEF_RANGE_LOW;
      model_cfg.range_high = DEF_RANGE_HIGH;
      model_phase = PHASE_BOOT;
      model_status = ST_POWER;
      model_levels = '0;
      model_pending = '0;
      foreach (model_settle[i]) model_settle[i] = '0;
      power_left = '0;
      acquire_left = '0;
      power_armed = 1'b0;
      acquire_armed = 1'b0;
      model_laser = 1'b0;
      model_camera = 1'b0;
      model_heater_probe = 1'b0;
      model_setpoint = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_power_on_defaults();
      test_launch_chain();
      test_sensor_choice();
      test_backpressure();
      test_random_flights();

      wait_until_drained();
      repeat (8) @(negedge clock);
      $display("Covered %0d ticks and %0d forced commands over %0d register settings.",
               ticks_taken, forces_taken, settings_applied + 1);
      $display("Checked %0d results, %0d acquisition-end pulses, %0d experiment entries.",
               results_checked, end_pulses, experiment_entries);
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("PASS flight_phase_sequencer");
      end else begin
         if (expected_reports.size() != 0) begin
            $error("%0d predicted results never arrived", expected_reports.size());
         end
         $display("FAIL flight_phase_sequencer");
      end
      $finish;
   end

endmodule
